### src/skbs_pkg.sv
package skbs_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 24;
  localparam int STAT_W = 2;
  localparam int POS_W  = 12;
  localparam int HELD_W = 13;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

endpackage

### src/skbs_req_if.sv
interface skbs_req_if import skbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

### src/skbs_rsp_if.sv
interface skbs_rsp_if import skbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;
  logic [HELD_W-1:0] entries_held;

  modport source (output valid, output status, output position, output entries_held,
                  input ready);
  modport sink   (input valid, input status, input position, input entries_held,
                  output ready);
endinterface

### src/skbs_ram.sv
module skbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sorted_key_binary_search_unit.sv
// Channel  Dir  Modport  Payload
// req      in   sink     operation[1:0], key[23:0]
// rsp      out  source   status[1:0], position[11:0], entries_held[12:0]
//
// Append, clear and the unused code are answered without a search; the result is registered.
// Lookup: an empty table answers EMPTY without a search; else an issue step, then
// key RAM probes (registered read), at most ceil(log2(n+1)) for n keys held, 13 at 4096.
// rst is synchronous: entry count cleared, no result pending. Key RAM not cleared.
// req.ready is low while a search runs and while an unread result blocks the output
// register; a search that finishes against a stalled output holds its last probe.
module sorted_key_binary_search_unit import skbs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  skbs_req_if.sink    req,
  skbs_rsp_if.source  rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t            state;
  logic [CW-1:0]     count;
  // search window is [lo, hip1); mid is the probe in flight
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hip1;
  logic [AW-1:0]     mid;
  logic [KEY_W-1:0]  skey;

  logic              rsp_valid;
  logic [STAT_W-1:0] rsp_status;
  logic [POS_W-1:0]  rsp_position;
  logic [HELD_W-1:0] rsp_held;

  logic              out_free;
  logic              accept;
  logic              full;
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [KEY_W-1:0]  probe;

  logic [SW-1:0]     mid_ext;
  logic [SW-1:0]     lo_ext;
  logic [SW-1:0]     hip1_ext;
  logic [SW-1:0]     mid_p1;
  logic [SW-1:0]     sum_up;
  logic [SW-1:0]     sum_dn;
  logic [SW-1:0]     sum_init;
  logic [AW-1:0]     mid_up;
  logic [AW-1:0]     mid_dn;
  logic [AW-1:0]     mid_init;
  logic              hit;
  logic              go_up;
  logic              finish;

  logic [CW-1:0]        count_inc;
  logic [CW+HELD_W-1:0] held_cur_w;
  logic [CW+HELD_W-1:0] held_inc_w;
  logic [AW+POS_W-1:0]  pos_w;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = (count >= CW'(TABLE_DEPTH));

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.position     = rsp_position;
  assign rsp.entries_held = rsp_held;

  // next-probe candidates for both compare outcomes, worked out in parallel
  assign mid_ext  = {{(SW-AW){1'b0}}, mid};
  assign lo_ext   = {1'b0, lo};
  assign hip1_ext = {1'b0, hip1};
  assign mid_p1   = mid_ext + SW'(1);
  assign sum_up   = mid_ext + hip1_ext;
  assign sum_dn   = lo_ext + mid_ext - SW'(1);
  assign sum_init = {1'b0, count} - SW'(1);
  assign mid_up   = sum_up[AW:1];
  assign mid_dn   = sum_dn[AW:1];
  assign mid_init = sum_init[AW:1];

  assign hit    = (probe == skey);
  assign go_up  = (probe < skey);
  assign finish = hit || (go_up ? !(mid_p1 < hip1_ext) : !(lo_ext < mid_ext));

  always_comb begin
    if (state == S_IDLE) begin
      ram_raddr = mid_init;
    end else if (finish) begin
      ram_raddr = mid;            // hold the probe while the output stalls
    end else if (go_up) begin
      ram_raddr = mid_up;
    end else begin
      ram_raddr = mid_dn;
    end
  end

  assign ram_we = accept && (req.operation == OP_APPEND) && !full;

  assign count_inc  = count + CW'(1);
  assign held_cur_w = {{HELD_W{1'b0}}, count};
  assign held_inc_w = {{HELD_W{1'b0}}, count_inc};
  assign pos_w      = {{POS_W{1'b0}}, mid};

  skbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (req.key),
    .raddr (ram_raddr),
    .rdata (probe)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.operation)
              OP_APPEND: begin
                rsp_valid    <= 1'b1;
                rsp_position <= '0;
                if (full) begin
                  rsp_status <= ST_FULL;
                  rsp_held   <= held_cur_w[HELD_W-1:0];
                end else begin
                  count      <= count_inc;
                  rsp_status <= ST_OK;
                  rsp_held   <= held_inc_w[HELD_W-1:0];
                end
              end
              OP_LOOKUP: begin
                if (count == '0) begin
                  rsp_valid    <= 1'b1;
                  rsp_status   <= ST_EMPTY;
                  rsp_position <= '0;
                  rsp_held     <= '0;
                end else begin
                  lo    <= '0;
                  hip1  <= count;
                  mid   <= mid_init;
                  skey  <= req.key;
                  state <= S_SEARCH;
                end
              end
              OP_CLEAR: begin
                count        <= '0;
                rsp_valid    <= 1'b1;
                rsp_status   <= ST_OK;
                rsp_position <= '0;
                rsp_held     <= '0;
              end
              default: begin
                rsp_valid    <= 1'b1;
                rsp_status   <= ST_OK;
                rsp_position <= '0;
                rsp_held     <= held_cur_w[HELD_W-1:0];
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (finish) begin
            if (out_free) begin
              rsp_valid    <= 1'b1;
              rsp_status   <= hit ? ST_OK : ST_MISS;
              rsp_position <= hit ? pos_w[POS_W-1:0] : '0;
              rsp_held     <= held_cur_w[HELD_W-1:0];
              state        <= S_IDLE;
            end
          end else if (go_up) begin
            lo  <= mid_p1[CW-1:0];
            mid <= mid_up;
          end else begin
            hip1 <= mid_ext[CW-1:0];
            mid  <= mid_dn;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_window_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo < hip1))
    else $error("search window empty while searching");

  a_probe_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ((lo_ext <= mid_ext) && (mid_ext < hip1_ext)))
    else $error("probe outside search window");

  a_probe_below_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (hip1 <= count))
    else $error("search reaches beyond held entries");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.operation == OP_CLEAR)) |=> (count == '0))
    else $error("clear left entries held");
`endif

endmodule

### test/sorted_key_binary_search_unit_tb.sv
module sorted_key_binary_search_unit_tb import skbs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  // Op code 3 has no name in the package; the block must treat it as a no-op.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int RESET_CYCLES = 11;
  // Covers the longest search plus the registered result, with a little margin on top.
  localparam int SETTLE_CYCLES = 20;
  // Cycles with no handshake on either side before the run is called hung.
  localparam int HANG_LIMIT = 5000;
  localparam int PHASE_REQUESTS = 350;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } search_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [HELD_W-1:0] entries_held;
  } search_rsp_t;

  logic clk = 1'b0;
  logic rst;

  skbs_req_if req_ch ();
  skbs_rsp_if rsp_ch ();

  sorted_key_binary_search_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and results the table is owed, oldest first.
  search_req_t pending_requests[$];
  search_rsp_t owed_results[$];

  // Idling rates for the current phase, in percent.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          req_taken = 1'b0;

  // Predictor state: our own copy of the key table and its fill level.
  logic [KEY_W-1:0]  model_keys [TABLE_DEPTH];
  logic [HELD_W-1:0] model_count = '0;

  // Stimulus-side shadow of the table, only used to pick keys worth looking up.
  logic [KEY_W-1:0] gen_keys [TABLE_DEPTH];
  int unsigned      gen_count = 0;
  int unsigned      requests_queued = 0;

  // Applies one request to the predicted table and returns the result it owes.
  function automatic search_rsp_t apply_request(search_req_t r);
    search_rsp_t res;
    int lo;
    int hi;
    int mid;
    res.status       = ST_OK;
    res.position     = '0;
    res.entries_held = '0;
    case (r.operation)
      OP_APPEND: begin
        if (model_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;   // full: key dropped, count unchanged
        end else begin
          model_keys[model_count[IDX_W-1:0]] = r.key;
          model_count = model_count + 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // plain binary search over the held entries; first probe to match wins,
          // which settles duplicates and unsorted tables the same way the block does
          lo = 0;
          hi = int'(model_count) - 1;
          res.status = ST_MISS;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (model_keys[mid[IDX_W-1:0]] == r.key) begin
              res.status   = ST_OK;
              res.position = mid[POS_W-1:0];
              break;
            end else if (model_keys[mid[IDX_W-1:0]] < r.key) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
        end
      end
      OP_CLEAR: begin
        model_count = '0;   // keys stay in the table but are out of reach
      end
      default: begin
      end
    endcase
    res.entries_held = model_count;
    return res;
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    search_req_t r;
    r.operation = op;
    r.key       = key;
    pending_requests.push_back(r);
    requests_queued++;
    if (op == OP_APPEND && gen_count < TABLE_DEPTH) begin
      gen_keys[gen_count[IDX_W-1:0]] = key;
      gen_count++;
    end else if (op == OP_CLEAR) begin
      gen_count = 0;
    end
  endtask

  // Appends n random keys in ascending order; optionally pins the key range ends.
  task automatic append_sorted(input int unsigned n, input bit pin_ends);
    int unsigned ks[$];
    repeat (n) ks.push_back($urandom_range(24'hFFFFFF));
    ks.sort();
    if (pin_ends && n > 1) begin
      ks[0] = 0;
      ks[n-1] = 24'hFFFFFF;
    end
    foreach (ks[i]) queue_request(OP_APPEND, KEY_W'(ks[i]));
  endtask

  // Mostly held keys (hits), then their neighbours, then anything at all.
  task automatic queue_lookup();
    int unsigned pick;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(99);
    if (gen_count == 0 || pick >= 85) begin
      k = KEY_W'($urandom);
    end else begin
      k = gen_keys[IDX_W'($urandom_range(gen_count - 1))];
      if (pick >= 60) k = pick[0] ? k + 1'b1 : k - 1'b1;
    end
    queue_request(OP_LOOKUP, k);
  endtask

  // Well-formed runs (clear, sorted load, lookups) with some noise between them.
  task automatic run_mixed(input int unsigned target);
    int unsigned start;
    int unsigned roll;
    int unsigned n;
    start = requests_queued;
    while (requests_queued - start < target) begin
      if ($urandom_range(99) < 80) begin
        queue_request(OP_CLEAR, KEY_W'($urandom));
        roll = $urandom_range(99);
        if (roll < 80)      n = $urandom_range(1, 24);
        else if (roll < 95) n = $urandom_range(25, 200);
        else                n = $urandom_range(201, 400);
        append_sorted(n, 1'b0);
        repeat ($urandom_range(1, 24)) queue_lookup();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_request(OP_W'($urandom_range(3)), KEY_W'($urandom));
        end
      end
    end
  endtask

  // Sender holds off until the table has answered every request, then settles.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || req_ch.valid || owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request side: note acceptance at the rising edge and predict the result there.
  always @(posedge clk) begin : note_requests
    search_req_t r;
    req_taken = !rst && req_ch.valid && req_ch.ready;
    if (req_taken) begin
      r.operation = req_ch.operation;
      r.key       = req_ch.key;
      owed_results.push_back(apply_request(r));
    end
  end

  // Request driver: one assignment per signal per falling edge.
  always @(negedge clk) begin : drive_requests
    search_req_t nxt;
    logic        nv;
    nv  = req_ch.valid;
    nxt.operation = req_ch.operation;
    nxt.key       = req_ch.key;
    if (rst) begin
      nv = 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nv  = 1'b1;
        nxt = pending_requests.pop_front();
      end else begin
        nv  = 1'b0;
        nxt.operation = OP_W'($urandom);    // junk payload while idle
        nxt.key       = KEY_W'($urandom);
      end
    end
    req_ch.valid     <= nv;
    req_ch.operation <= nxt.operation;
    req_ch.key       <= nxt.key;
  end

  // Result side: random back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    search_rsp_t got;
    search_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status       = rsp_ch.status;
      got.position     = rsp_ch.position;
      got.entries_held = rsp_ch.entries_held;
      if (owed_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("%0t: result with no request outstanding: status %0d position %0d %s %0d",
                   $realtime, got.status, got.position, "held", got.entries_held);
        end
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        if (got.status !== want.status || got.position !== want.position ||
            got.entries_held !== want.entries_held) begin
          if (mismatch_count < 10) begin
            $display({"%0t: mismatch: status exp %0d got %0d, ",
                      "position exp %0d got %0d, held exp %0d got %0d"},
                     $realtime, want.status, got.status, want.position, got.position,
                     want.entries_held, got.entries_held);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Hang detector: counts cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("timeout: no request or result moved in %0d cycles", HANG_LIMIT);
      $display("sorted_key_binary_search_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_APPEND;
    req_ch.key       = '0;
    rsp_ch.ready     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, spare op, key extremes, duplicate, unsorted load, clear.
    queue_request(OP_LOOKUP, 24'h000000);
    queue_request(OP_SPARE,  24'hFFFFFF);
    queue_request(OP_APPEND, 24'h000000);
    queue_request(OP_APPEND, 24'h000001);
    queue_request(OP_APPEND, 24'h7FFFFF);
    queue_request(OP_APPEND, 24'h800000);
    queue_request(OP_APPEND, 24'hFFFFFE);
    queue_request(OP_APPEND, 24'hFFFFFF);
    queue_request(OP_LOOKUP, 24'h000000);
    queue_request(OP_LOOKUP, 24'hFFFFFF);
    queue_request(OP_LOOKUP, 24'h800000);
    queue_request(OP_LOOKUP, 24'h400000);
    queue_request(OP_LOOKUP, 24'h000002);
    queue_request(OP_APPEND, 24'hFFFFFF);   // duplicate of the top key
    queue_request(OP_LOOKUP, 24'hFFFFFF);
    queue_request(OP_APPEND, 24'h000002);   // breaks ascending order
    queue_request(OP_LOOKUP, 24'h000002);
    queue_request(OP_SPARE,  24'h555555);
    queue_request(OP_CLEAR,  24'hAAAAAA);
    queue_request(OP_LOOKUP, 24'h000001);
    queue_request(OP_APPEND, 24'h123456);
    queue_request(OP_LOOKUP, 24'h123456);
    queue_request(OP_LOOKUP, 24'h123455);
    queue_request(OP_LOOKUP, 24'h123457);
    wait_drained();

    // Fill to the last slot, push against the full table, search at both ends.
    queue_request(OP_CLEAR, 24'h0);
    append_sorted(TABLE_DEPTH, 1'b1);
    repeat (3) queue_request(OP_APPEND, KEY_W'($urandom));
    queue_request(OP_LOOKUP, gen_keys[0]);
    queue_request(OP_LOOKUP, gen_keys[TABLE_DEPTH-1]);
    queue_request(OP_LOOKUP, gen_keys[TABLE_DEPTH/2]);
    repeat (60) queue_lookup();
    queue_request(OP_SPARE, KEY_W'($urandom));
    queue_request(OP_CLEAR, KEY_W'($urandom));
    run_mixed(PHASE_REQUESTS);
    wait_drained();

    // Sender idle most of the time.
    send_idle_pct  = 67;
    recv_stall_pct = 0;
    run_mixed(PHASE_REQUESTS);
    wait_drained();

    // Receiver stalling most of the time.
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    run_mixed(PHASE_REQUESTS);
    wait_drained();

    // Light idling on both sides.
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    run_mixed(PHASE_REQUESTS);
    wait_drained();

    if (owed_results.size() != 0) begin
      $display("%0d results never arrived", owed_results.size());
    end
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("sorted_key_binary_search_unit_tb OK");
    end else begin
      $display("sorted_key_binary_search_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
src/skbs_pkg.sv
src/skbs_req_if.sv
src/skbs_rsp_if.sv
src/skbs_ram.sv
src/sorted_key_binary_search_unit.sv
test/sorted_key_binary_search_unit_tb.sv
